@@ rtl/chime_pkg.sv @@
package chime_pkg;

  // sizing
  localparam int NOTE_COUNT     = 4;
  localparam int FREQ_REGS      = 4;
  localparam int SINE_ENTRIES   = 1024;
  localparam int DECAY_ENTRIES  = 256;
  localparam int TIME_FRAC_BITS = 16;

  localparam int TIME_W   = 32;
  localparam int FREQ_W   = 20;
  localparam int PEAK_W   = 14;
  localparam int SAMPLE_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NOTE0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FUND  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_HARM  = 3'd5;

  // reset values
  localparam logic [FREQ_W-1:0] FREQ_RST [FREQ_REGS] = '{20'd133952, 20'd168768,
                                                          20'd200701, 20'd267904};
  localparam logic [PEAK_W-1:0] FUND_RST = 14'd9000;
  localparam logic [PEAK_W-1:0] HARM_RST = 14'd1620;

  // time constants in units of 2^-F s
  localparam longint ONE_T   = longint'(1) << TIME_FRAC_BITS;
  localparam longint SPACING = (7 * ONE_T + 25) / 50;
  localparam longint ATTACK  = (ONE_T + 125) / 250;
  localparam longint AUDIBLE = (13 * ONE_T + 25) / 50;
  localparam longint SPAN    = AUDIBLE - ATTACK;

  // phrase time: period is 3 << (F-1)
  localparam int PT_W = TIME_FRAC_BITS + 1;
  localparam int X_W  = TIME_W - (TIME_FRAC_BITS - 1);
  localparam int M3_W = X_W - 1;
  localparam longint M3 = (longint'(1) << X_W) / 3;

  // envelope division by reciprocal
  localparam int ENV_SHIFT = 15;
  localparam int DECAY_BITS = $clog2(DECAY_ENTRIES);
  localparam longint NUM_MAX_A = (ATTACK - 1) << ENV_SHIFT;
  localparam longint NUM_MAX_D = (SPAN - 1) * DECAY_ENTRIES;
  localparam int NUM_W = $clog2(((NUM_MAX_A > NUM_MAX_D) ? NUM_MAX_A : NUM_MAX_D) + 1);
  localparam int RECIP_SH = NUM_W;
  localparam longint M_ATK = (longint'(1) << RECIP_SH) / ATTACK;
  localparam longint M_DEC = (longint'(1) << RECIP_SH) / SPAN;
  localparam int DIV_W = $clog2(SPAN + 1);
  localparam int ENV_W = 17;

  // phase and mixing widths
  localparam int SINE_BITS = $clog2(SINE_ENTRIES);
  localparam int QBITS     = SINE_BITS - 2;
  localparam int QUARTER   = SINE_ENTRIES / 4;
  localparam int PROD_W    = FREQ_W + TIME_W;
  localparam int PH_TOP    = 8 + TIME_FRAC_BITS - 1;
  localparam int SIN_W     = 16;
  localparam int TONE_W    = 32;
  localparam int TERM_W    = ENV_W + 1 + TONE_W;
  localparam int ACC_W     = TERM_W + 4;
  localparam int OUT_SHIFT = 30;
  localparam int CLIP      = 32000;
  localparam int LAT       = 8;

  typedef logic [SIN_W-1:0] sine_tab_t [QUARTER+1];
  typedef logic [ENV_W-1:0] decay_tab_t [DECAY_ENTRIES];

  typedef struct packed {
    logic [FREQ_REGS-1:0][FREQ_W-1:0] freq;
    logic [PEAK_W-1:0]                fund;
    logic [PEAK_W-1:0]                harm;
  } cfg_t;

  // shift and subtract long division for table generation
  function automatic longint unsigned udiv(longint unsigned num, longint unsigned den);
    longint unsigned q, r;
    q = '0;
    r = '0;
    for (int b = 63; b >= 0; b--) begin
      r = (r << 1) | ((num >> b) & 64'd1);
      if (r >= den) begin
        r = r - den;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // signed quotient, truncated toward zero
  function automatic longint sdiv(longint num, longint unsigned den);
    longint unsigned mag, q;
    mag = (num < 0) ? -num : num;
    q = udiv(mag, den);
    return (num < 0) ? -longint'(q) : longint'(q);
  endfunction

  // quarter-wave sine, Q30 series, rounded to 32767 full scale
  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    longint one, hp, r, a, a2, term, sum, v;
    one = longint'(1) << 30;
    hp  = 64'd1686629713;
    for (int i = 0; i <= QUARTER; i++) begin
      r = longint'(i) << (32 - SINE_BITS);
      if (r > one) r = one;
      a = (r * hp) >>> 30;
      a2 = sdiv(a * a, one);
      term = a;
      sum = a;
      for (int k = 1; k <= 7; k++) begin
        term = -sdiv(sdiv(term * a2, one), longint'((2 * k) * (2 * k + 1)));
        sum += term;
      end
      if (sum < 0) sum = 0;
      if (sum > one) sum = one;
      v = sdiv(sum * 32767 + (one >>> 1), one);
      tab[i] = v[SIN_W-1:0];
    end
    return tab;
  endfunction

  // decay curve, series for exp(z), inverted and squared three times
  function automatic decay_tab_t build_decay();
    decay_tab_t tab;
    longint unsigned one, z, term, e, v;
    one = 64'd1 << 30;
    for (int j = 0; j < DECAY_ENTRIES; j++) begin
      z = udiv((longint'(j) * 128) << 30, 360 * DECAY_ENTRIES);
      term = one;
      e = one;
      for (int k = 1; k <= 12; k++) begin
        term = udiv(udiv(term * z, one), longint'(k));
        e += term;
      end
      v = udiv((64'd1 << 60) + (e >> 1), e);
      for (int k = 0; k < 3; k++) v = (v * v + (one >> 1)) >> 30;
      v = (v + 16384) >> 15;
      tab[j] = v[ENV_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t  SINE_TAB  = build_sine();
  localparam decay_tab_t DECAY_TAB = build_decay();

  // full-wave sine from the quarter table
  function automatic logic signed [SIN_W-1:0] sine_lookup(logic [SINE_BITS-1:0] idx);
    logic [QBITS:0]   ri;
    logic [SIN_W-1:0] mag;
    ri = idx[QBITS-2] ? (QBITS+1)'(0) : (QBITS+1)'(0);
    if (idx[SINE_BITS-2]) ri = (QBITS+1)'(QUARTER) - {1'b0, idx[QBITS-1:0]};
    else ri = {1'b0, idx[QBITS-1:0]};
    mag = SINE_TAB[ri];
    return idx[SINE_BITS-1] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic [PT_W-1:0] note_start(int n);
    longint s;
    s = longint'(n) * SPACING;
    return s[PT_W-1:0];
  endfunction

endpackage

@@ rtl/chime_cfg.sv @@
module chime_cfg (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_valid_i,
  input  logic [chime_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [chime_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output chime_pkg::cfg_t                      cfg_o
);

  chime_pkg::cfg_t cfg_q, cfg_d;

  // register writes, out-of-range indexes dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      for (int n = 0; n < chime_pkg::FREQ_REGS; n++) begin
        if (cfg_index_i == chime_pkg::CFG_NOTE0 + chime_pkg::CFG_IDX_W'(n)) begin
          cfg_d.freq[n] = cfg_data_i[chime_pkg::FREQ_W-1:0];
        end
      end
      if (cfg_index_i == chime_pkg::CFG_FUND) begin
        cfg_d.fund = cfg_data_i[chime_pkg::PEAK_W-1:0];
      end
      if (cfg_index_i == chime_pkg::CFG_HARM) begin
        cfg_d.harm = cfg_data_i[chime_pkg::PEAK_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < chime_pkg::FREQ_REGS; n++) begin
        cfg_q.freq[n] <= chime_pkg::FREQ_RST[n];
      end
      cfg_q.fund <= chime_pkg::FUND_RST;
      cfg_q.harm <= chime_pkg::HARM_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/chime_lane.sv @@
module chime_lane (
  input  logic                                    clk_i,
  input  logic [chime_pkg::FREQ_W-1:0]            freq_i,
  input  logic [chime_pkg::PEAK_W-1:0]            fund_i,
  input  logic [chime_pkg::PEAK_W-1:0]            harm_i,
  input  logic [chime_pkg::TIME_W-1:0]            time_i,
  input  logic [chime_pkg::PT_W-1:0]              pt_i,
  input  logic [chime_pkg::PT_W-1:0]              start_i,
  output logic signed [chime_pkg::TERM_W-1:0]     term_o
);

  // stage 2: phase product and note time
  logic [chime_pkg::PROD_W-1:0] prod_q;
  logic [chime_pkg::PT_W-1:0]   nt_q;
  logic                         ge_q;

  always_ff @(posedge clk_i) begin
    prod_q <= chime_pkg::PROD_W'(freq_i) * chime_pkg::PROD_W'(time_i);
    nt_q   <= pt_i - start_i;
    ge_q   <= pt_i >= start_i;
  end

  // stage 3: envelope numerator and sine lookups
  logic                                act_d, atk_d;
  logic [chime_pkg::NUM_W-1:0]         num_d;
  logic [chime_pkg::SINE_BITS-1:0]     idx1, idx2;
  logic                                act3_q, atk3_q;
  logic [chime_pkg::NUM_W-1:0]         num3_q;
  logic signed [chime_pkg::SIN_W-1:0]  s1_q, s2_q;

  always_comb begin
    act_d = ge_q && (nt_q < chime_pkg::PT_W'(chime_pkg::AUDIBLE));
    atk_d = nt_q < chime_pkg::PT_W'(chime_pkg::ATTACK);
    if (atk_d) begin
      num_d = chime_pkg::NUM_W'(nt_q) << chime_pkg::ENV_SHIFT;
    end else begin
      num_d = chime_pkg::NUM_W'(nt_q - chime_pkg::PT_W'(chime_pkg::ATTACK))
              << chime_pkg::DECAY_BITS;
    end
    idx1 = prod_q[chime_pkg::PH_TOP -: chime_pkg::SINE_BITS];
    idx2 = prod_q[chime_pkg::PH_TOP-1 -: chime_pkg::SINE_BITS];
  end

  always_ff @(posedge clk_i) begin
    act3_q <= act_d;
    atk3_q <= atk_d;
    num3_q <= num_d;
    s1_q   <= chime_pkg::sine_lookup(idx1);
    s2_q   <= chime_pkg::sine_lookup(idx2);
  end

  // stage 4: reciprocal estimate and tone mix
  logic [2*chime_pkg::NUM_W-1:0]       rprod;
  logic [chime_pkg::NUM_W-1:0]         recip;
  logic [chime_pkg::NUM_W-1:0]         q0_q, num4_q;
  logic                                act4_q, atk4_q;
  logic signed [chime_pkg::TONE_W-1:0] tone4_q;
  logic signed [chime_pkg::TONE_W-1:0] tone_d;

  always_comb begin
    recip = atk3_q ? chime_pkg::NUM_W'(chime_pkg::M_ATK) : chime_pkg::NUM_W'(chime_pkg::M_DEC);
    rprod = (2*chime_pkg::NUM_W)'(num3_q) * (2*chime_pkg::NUM_W)'(recip);
    tone_d = chime_pkg::TONE_W'($signed({1'b0, fund_i})) * chime_pkg::TONE_W'(s1_q)
           + chime_pkg::TONE_W'($signed({1'b0, harm_i})) * chime_pkg::TONE_W'(s2_q);
  end

  always_ff @(posedge clk_i) begin
    q0_q    <= rprod[chime_pkg::RECIP_SH +: chime_pkg::NUM_W];
    num4_q  <= num3_q;
    act4_q  <= act3_q;
    atk4_q  <= atk3_q;
    tone4_q <= tone_d;
  end

  // stage 5: quotient correction and decay lookup
  localparam int RW = chime_pkg::NUM_W + chime_pkg::DIV_W;
  logic [chime_pkg::DIV_W-1:0]         div;
  logic [RW-1:0]                       rem;
  logic [chime_pkg::NUM_W-1:0]         quo;
  logic [chime_pkg::ENV_W-1:0]         env_d, env5_q;
  logic signed [chime_pkg::TONE_W-1:0] tone5_q;

  always_comb begin
    div = atk4_q ? chime_pkg::DIV_W'(chime_pkg::ATTACK) : chime_pkg::DIV_W'(chime_pkg::SPAN);
    rem = RW'(num4_q) - RW'(q0_q) * RW'(div);
    quo = (rem >= RW'(div)) ? q0_q + 1'b1 : q0_q;
    if (!act4_q) begin
      env_d = '0;
    end else if (atk4_q) begin
      env_d = chime_pkg::ENV_W'(quo);
    end else begin
      env_d = chime_pkg::DECAY_TAB[quo[chime_pkg::DECAY_BITS-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    env5_q  <= env_d;
    tone5_q <= tone4_q;
  end

  // stage 6: envelope times tone
  logic signed [chime_pkg::TERM_W-1:0] term_q;

  always_ff @(posedge clk_i) begin
    term_q <= $signed({1'b0, env5_q}) * tone5_q;
  end

  assign term_o = term_q;

endmodule

@@ rtl/chime_sample_synth_unit.sv @@
// a sample appears on sample_o with valid_o once its time value has passed the capture, lane, sum and output stages
// throughput: one time value per cycle, set by the fully pipelined note lanes
// busy_o stays low; results cannot be held off and leave one per strobe
// reset clears the stage valid bits and loads the default note and peak registers
module chime_sample_synth_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [chime_pkg::TIME_W-1:0]        time_q16_i,
  output logic                                valid_o,
  output logic signed [chime_pkg::SAMPLE_W-1:0] sample_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [chime_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [chime_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int F = chime_pkg::TIME_FRAC_BITS;

  chime_pkg::cfg_t cfg;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  chime_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // valid bits, one per stage
  logic [chime_pkg::LAT-1:0] vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[chime_pkg::LAT-2:0], start_i & ~busy_o};
    end
  end

  // stage 1: capture time, estimate the period count
  logic [chime_pkg::TIME_W-1:0] t_q;
  logic [chime_pkg::X_W-1:0]    x_in;
  logic [2*chime_pkg::X_W-1:0]  q3_prod;
  logic [chime_pkg::X_W-1:0]    q3_q;

  assign x_in    = time_q16_i[chime_pkg::TIME_W-1:F-1];
  assign q3_prod = (2*chime_pkg::X_W)'(x_in) * (2*chime_pkg::X_W)'(chime_pkg::M3);

  always_ff @(posedge clk_i) begin
    t_q  <= time_q16_i;
    q3_q <= q3_prod[chime_pkg::X_W +: chime_pkg::X_W];
  end

  // phrase time from the corrected remainder
  logic [chime_pkg::X_W-1:0]  x1, rem0, rem1;
  logic [chime_pkg::PT_W-1:0] pt;

  always_comb begin
    x1   = t_q[chime_pkg::TIME_W-1:F-1];
    rem0 = x1 - (q3_q + (q3_q << 1));
    rem1 = (rem0 >= chime_pkg::X_W'(3)) ? rem0 - chime_pkg::X_W'(3) : rem0;
    pt   = {rem1[1:0], t_q[F-2:0]};
  end

  // note lanes
  logic signed [chime_pkg::TERM_W-1:0] term [chime_pkg::NOTE_COUNT];

  for (genvar n = 0; n < chime_pkg::NOTE_COUNT; n++) begin : g_lane
    logic [chime_pkg::FREQ_W-1:0] freq;
    if (n < chime_pkg::FREQ_REGS) begin : g_reg
      assign freq = cfg.freq[n];
    end else begin : g_zero
      assign freq = '0;
    end
    chime_lane u_lane (
      .clk_i   (clk_i),
      .freq_i  (freq),
      .fund_i  (cfg.fund),
      .harm_i  (cfg.harm),
      .time_i  (t_q),
      .pt_i    (pt),
      .start_i (chime_pkg::note_start(n)),
      .term_o  (term[n])
    );
  end

  // stage 7: sum of notes
  logic signed [chime_pkg::ACC_W-1:0] acc_d, acc_q;

  always_comb begin
    acc_d = '0;
    for (int n = 0; n < chime_pkg::NOTE_COUNT; n++) begin
      acc_d = acc_d + chime_pkg::ACC_W'(term[n]);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // stage 8: scale toward zero and clip
  logic signed [chime_pkg::ACC_W-1:0]   biased, scaled;
  logic signed [chime_pkg::SAMPLE_W-1:0] sample_d, sample_q;

  always_comb begin
    biased = acc_q;
    if (acc_q < 0) begin
      biased = acc_q + chime_pkg::ACC_W'((64'd1 << chime_pkg::OUT_SHIFT) - 64'd1);
    end
    scaled = biased >>> chime_pkg::OUT_SHIFT;
    if (scaled > chime_pkg::ACC_W'(chime_pkg::CLIP)) begin
      sample_d = chime_pkg::SAMPLE_W'(chime_pkg::CLIP);
    end else if (scaled < -chime_pkg::ACC_W'(chime_pkg::CLIP)) begin
      sample_d = -chime_pkg::SAMPLE_W'(chime_pkg::CLIP);
    end else begin
      sample_d = scaled[chime_pkg::SAMPLE_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    sample_q <= sample_d;
  end

  assign sample_o = sample_q;
  assign valid_o  = vld_q[chime_pkg::LAT-1];

  // every accepted beat comes out a fixed latency later
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##8 valid_o)
    else $error("accepted beat did not produce a sample");

  // clipped range on every strobe
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (sample_o <= 16'sd32000 && sample_o >= -16'sd32000))
    else $error("sample outside clip range");

  // sum stage feeds the output stage
  a_sum_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[chime_pkg::LAT-2] |=> valid_o)
    else $error("sum stage valid lost");

endmodule

@@ bench/tb_chime_sample_synth_unit.sv @@
module tb_chime_sample_synth_unit;

  timeunit 1ns;
  timeprecision 1ps;

  // time constants for F = 16, in units of 2^-16 s
  localparam longint unsigned PHRASE_LEN = 98304;
  localparam longint unsigned NOTE_GAP   = 9175;
  localparam longint unsigned ATK_LEN    = 262;
  localparam longint unsigned RING_LEN   = 17039;
  localparam longint unsigned DEC_SPAN   = RING_LEN - ATK_LEN;
  localparam longint          Q30        = 64'sd1 << 30;
  localparam logic [chime_pkg::CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [chime_pkg::CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int STALL_LIMIT = 5000;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  logic [chime_pkg::TIME_W-1:0] time_q16_i;
  logic valid_o;
  logic signed [chime_pkg::SAMPLE_W-1:0] sample_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [chime_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [chime_pkg::CFG_DATA_W-1:0] cfg_data_i;

  // predictor copy of the registers and tables
  logic [chime_pkg::FREQ_W-1:0] pitch [chime_pkg::FREQ_REGS];
  logic [chime_pkg::PEAK_W-1:0] fund_amp;
  logic [chime_pkg::PEAK_W-1:0] harm_amp;
  longint sine_rom [chime_pkg::SINE_ENTRIES];
  longint decay_rom [chime_pkg::DECAY_ENTRIES];

  logic signed [chime_pkg::SAMPLE_W-1:0] sample_q [$];
  int errors = 0;
  int stall_cnt = 0;
  bit steady = 0;

  chime_sample_synth_unit i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .time_q16_i, .valid_o, .sample_o,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // full-wave sine and decay curve in Q30 series arithmetic
  task automatic fill_tables();
    longint p, r, a, a2, term, sum, v;
    longint unsigned z, t, e, w;
    int quad;
    for (int i = 0; i < chime_pkg::SINE_ENTRIES; i++) begin
      p = (longint'(i) << 32) / chime_pkg::SINE_ENTRIES;
      quad = int'((p >> 30) & 3);
      r = p & (Q30 - 1);
      if (quad[0]) r = Q30 - r;
      a = (r * 64'sd1686629713) >>> 30;
      a2 = (a * a) / Q30;
      term = a;
      sum = a;
      for (int k = 1; k <= 7; k++) begin
        term = -(term * a2 / Q30) / longint'((2 * k) * (2 * k + 1));
        sum += term;
      end
      if (sum < 0) sum = 0;
      if (sum > Q30) sum = Q30;
      v = (sum * 32767 + (Q30 >>> 1)) / Q30;
      sine_rom[i] = (quad >= 2) ? -v : v;
    end
    for (int j = 0; j < chime_pkg::DECAY_ENTRIES; j++) begin
      z = ((longint'(j) * 128) << 30) / (360 * chime_pkg::DECAY_ENTRIES);
      t = Q30;
      e = Q30;
      for (int k = 1; k <= 12; k++) begin
        t = t * z / Q30 / longint'(k);
        e += t;
      end
      w = ((64'd1 << 60) + e / 2) / e;
      for (int k = 0; k < 3; k++) w = (w * w + (Q30 >> 1)) >> 30;
      decay_rom[j] = longint'((w + 16384) >> 15);
    end
  endtask

  // expected chime sample at absolute time tq
  function automatic logic signed [chime_pkg::SAMPLE_W-1:0] chime_at(
      logic [chime_pkg::TIME_W-1:0] tq);
    longint unsigned pt, nt, prod, f1, f2, mask;
    longint env, tone, acc, s;
    mask = (64'd1 << 24) - 1;
    pt = longint'(tq) % PHRASE_LEN;
    acc = 0;
    for (int n = 0; n < chime_pkg::NOTE_COUNT; n++) begin
      if (pt >= n * NOTE_GAP && pt - n * NOTE_GAP < RING_LEN) begin
        nt = pt - n * NOTE_GAP;
        if (nt < ATK_LEN) env = longint'(nt * 32768 / ATK_LEN);
        else env = decay_rom[((nt - ATK_LEN) * chime_pkg::DECAY_ENTRIES / DEC_SPAN) %
                             chime_pkg::DECAY_ENTRIES];
        prod = (n < chime_pkg::FREQ_REGS) ? longint'(pitch[n]) * longint'(tq) : 0;
        f1 = prod & mask;
        f2 = (prod << 1) & mask;
        tone = longint'(fund_amp) * sine_rom[(f1 * chime_pkg::SINE_ENTRIES) >> 24] +
               longint'(harm_amp) * sine_rom[(f2 * chime_pkg::SINE_ENTRIES) >> 24];
        acc += env * tone;
      end
    end
    s = acc / Q30;
    if (s > chime_pkg::CLIP) s = chime_pkg::CLIP;
    if (s < -chime_pkg::CLIP) s = -chime_pkg::CLIP;
    return s[chime_pkg::SAMPLE_W-1:0];
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("%0t mismatch: %s", $realtime, what);
  endtask

  // result check, one beat per strobe
  always @(posedge clk_i) begin
    if (rst_ni && valid_o) begin
      if (sample_q.size() == 0) report_mismatch("sample with nothing pending");
      else if (sample_o !== sample_q[0]) begin
        report_mismatch($sformatf("sample %0d, want %0d", sample_o, sample_q[0]));
        void'(sample_q.pop_front());
      end else void'(sample_q.pop_front());
    end
  end

  // watchdog on cycles with no beat anywhere
  always @(posedge clk_i) begin
    if (valid_o || (start_i && !busy_o) || (cfg_valid_i && cfg_ready_o)) stall_cnt <= 0;
    else stall_cnt <= stall_cnt + 1;
    if (stall_cnt > STALL_LIMIT) begin
      $display("tb_chime_sample_synth_unit NOT OK");
      $finish;
    end
  end

  // one time value beat
  task automatic send_time(logic [chime_pkg::TIME_W-1:0] tq);
    while (!steady && $urandom_range(99) < 23) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i <= 1'b1;
    time_q16_i <= tq;
    @(negedge clk_i);
    while (busy_o) @(negedge clk_i);
    @(posedge clk_i);
    sample_q.push_back(chime_at(tq));
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (sample_q.size() != 0) @(posedge clk_i);
    repeat (chime_pkg::LAT + 4) @(posedge clk_i);
  endtask

  // register write, only while idle
  task automatic write_reg(logic [chime_pkg::CFG_IDX_W-1:0] idx,
                           logic [chime_pkg::CFG_DATA_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx < chime_pkg::CFG_NOTE0 + chime_pkg::FREQ_REGS) pitch[idx - chime_pkg::CFG_NOTE0] = val;
    else if (idx == chime_pkg::CFG_FUND) fund_amp = val[chime_pkg::PEAK_W-1:0];
    else if (idx == chime_pkg::CFG_HARM) harm_amp = val[chime_pkg::PEAK_W-1:0];
    @(posedge clk_i);
  endtask

  task automatic load_setting(logic [chime_pkg::FREQ_W-1:0] f0, logic [chime_pkg::FREQ_W-1:0] f1,
                              logic [chime_pkg::FREQ_W-1:0] f2, logic [chime_pkg::FREQ_W-1:0] f3,
                              logic [chime_pkg::CFG_DATA_W-1:0] fa,
                              logic [chime_pkg::CFG_DATA_W-1:0] ha);
    drain();
    write_reg(chime_pkg::CFG_NOTE0, f0);
    write_reg(chime_pkg::CFG_IDX_W'(chime_pkg::CFG_NOTE0 + 1), f1);
    write_reg(chime_pkg::CFG_IDX_W'(chime_pkg::CFG_NOTE0 + 2), f2);
    write_reg(chime_pkg::CFG_IDX_W'(chime_pkg::CFG_NOTE0 + 3), f3);
    write_reg(chime_pkg::CFG_FUND, fa);
    write_reg(chime_pkg::CFG_HARM, ha);
  endtask

  // random times, mostly inside the sounding part of a phrase
  task automatic random_times(int count);
    longint unsigned tq;
    for (int i = 0; i < count; i++) begin
      steady = (i >= count / 3 && i < count / 2);
      case ($urandom_range(9))
        0, 1: tq = {$urandom()};
        2: tq = longint'($urandom_range(43690)) * PHRASE_LEN +
                $urandom_range(chime_pkg::NOTE_COUNT - 1) * NOTE_GAP +
                $urandom_range(ATK_LEN + 3);
        default: tq = longint'($urandom_range(43690)) * PHRASE_LEN +
                      $urandom_range(3 * NOTE_GAP + RING_LEN + 50);
      endcase
      send_time(tq[chime_pkg::TIME_W-1:0]);
    end
    steady = 0;
  endtask

  // note boundaries and time field extremes, at whatever setting is loaded
  task automatic test_boundaries();
    send_time('0);
    send_time('1);
    for (int n = 0; n < chime_pkg::NOTE_COUNT; n++) begin
      send_time(chime_pkg::TIME_W'(n * NOTE_GAP));
      send_time(chime_pkg::TIME_W'(n * NOTE_GAP + ATK_LEN - 1));
      send_time(chime_pkg::TIME_W'(n * NOTE_GAP + ATK_LEN));
      send_time(chime_pkg::TIME_W'(n * NOTE_GAP + RING_LEN - 1));
      send_time(chime_pkg::TIME_W'(n * NOTE_GAP + RING_LEN));
    end
    send_time(chime_pkg::TIME_W'(PHRASE_LEN - 1));
    send_time(chime_pkg::TIME_W'(PHRASE_LEN));
    send_time(chime_pkg::TIME_W'(PHRASE_LEN * 43690 + 2 * NOTE_GAP + 500));
  endtask

  task automatic test_default_chime();
    random_times(250);
  endtask

  // loudest setting, masked peaks and clipping
  task automatic test_full_scale();
    load_setting('1, '1, '1, '1, '1, '1);
    test_boundaries();
    random_times(200);
  endtask

  // silence with zero pitch and zero peaks
  task automatic test_silent();
    load_setting('0, '0, '0, '0, '0, '0);
    random_times(60);
  endtask

  // writes to unused indexes must leave the registers alone
  task automatic test_spare_index();
    load_setting(chime_pkg::FREQ_W'($urandom()), chime_pkg::FREQ_W'($urandom()),
                 chime_pkg::FREQ_W'($urandom()), chime_pkg::FREQ_W'($urandom()),
                 chime_pkg::CFG_DATA_W'($urandom()), chime_pkg::CFG_DATA_W'($urandom()));
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '0);
    random_times(250);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 3; p++) begin
      load_setting(chime_pkg::FREQ_W'($urandom()), chime_pkg::FREQ_W'($urandom()),
                   chime_pkg::FREQ_W'($urandom()), chime_pkg::FREQ_W'($urandom()),
                   chime_pkg::CFG_DATA_W'($urandom_range(16383)),
                   chime_pkg::CFG_DATA_W'($urandom_range(16383)));
      random_times(90);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    time_q16_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = chime_pkg::CFG_NOTE0;
    cfg_data_i = '0;
    for (int k = 0; k < chime_pkg::FREQ_REGS; k++) pitch[k] = chime_pkg::FREQ_RST[k];
    fund_amp = chime_pkg::FUND_RST;
    harm_amp = chime_pkg::HARM_RST;
    fill_tables();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_boundaries();
    test_default_chime();
    test_full_scale();
    test_silent();
    test_spare_index();
    test_random_settings();
    drain();
    if (errors == 0) $display("tb_chime_sample_synth_unit OK");
    else $display("tb_chime_sample_synth_unit NOT OK");
    $finish;
  end

endmodule
